/* sv/ils_pkg.sv */
// ----------------------------------------------------------------------------
// ils_pkg: shared types and constants for the indexed list store
// Holds the operation codes, the controller states, the command that is
// broadcast to every storage cell, and the fixed field widths.
// ----------------------------------------------------------------------------
`default_nettype none

package ils_pkg;

    // Fixed field widths of the item and result beats.
    localparam int DATA_W       = 32;
    localparam int POS_W        = 7;
    localparam int OP_W         = 3;
    localparam int FPOS_W       = 6;
    localparam int LEN_W        = 7;

    // Default number of list entries.
    localparam int CAPACITY_DEF = 64;

    // Operation codes; the one unused code is refused.
    typedef enum logic [OP_W-1:0] {
        OP_APPEND = 3'd0,
        OP_INSERT = 3'd1,
        OP_SET    = 3'd2,
        OP_REMOVE = 3'd3,
        OP_GET    = 3'd4,
        OP_FIND   = 3'd5,
        OP_CLEAR  = 3'd6
    } t_op;

    // Controller states.
    typedef enum logic {
        S_IDLE,
        S_DONE
    } t_state;

    // Command broadcast to every cell on an accepted beat.
    typedef struct packed {
        logic ins;   // shift right from the position, load data at it
        logic wr;    // overwrite the entry at the position
        logic rem;   // shift left into the position
        logic rd;    // capture the entry at the position
        logic find;  // compare live entries against the data
    } t_cell_cmd;

endpackage

`default_nettype wire

/* sv/ils_cell.sv */
// ----------------------------------------------------------------------------
// ils_cell: one storage cell of the list chain
// Holds one entry. On an accepted beat it keeps its value, takes its left or
// right neighbor's value, or loads the broadcast data, and it captures a read
// tap and a match flag for the result reduction.
// ----------------------------------------------------------------------------
`default_nettype none

module ils_cell
    import ils_pkg::*;
#(
    parameter int PW = 7
) (
    input  wire logic              i_clk,
    input  wire logic              i_en,
    input  wire t_cell_cmd         i_cmd,
    input  wire logic [PW-1:0]     i_index,
    input  wire logic [PW-1:0]     i_pos,
    input  wire logic [PW-1:0]     i_count,
    input  wire logic [DATA_W-1:0] i_data,
    input  wire logic [DATA_W-1:0] i_left,
    input  wire logic [DATA_W-1:0] i_right,
    output logic      [DATA_W-1:0] o_value,
    output logic      [DATA_W-1:0] o_tap,
    output logic                   o_match
);

    logic [DATA_W-1:0] r_value;
    logic [DATA_W-1:0] n_value;
    logic [DATA_W-1:0] r_tap;
    logic [DATA_W-1:0] n_tap;
    logic              r_match;
    logic              n_match;
    logic              at_pos;

    assign at_pos = (i_index == i_pos);

    // Entry update: shifts move whole entries one cell along the chain.
    always_comb begin
        n_value = r_value;
        if (i_cmd.ins) begin
            if (at_pos) begin
                n_value = i_data;
            end else if (i_index > i_pos) begin
                n_value = i_left;
            end
        end else if (i_cmd.wr && at_pos) begin
            n_value = i_data;
        end else if (i_cmd.rem && (i_index >= i_pos)) begin
            n_value = i_right;
        end
    end

    // Read tap and match flag, both taken from the value before the update.
    always_comb begin
        n_tap   = (i_cmd.rd && at_pos) ? r_value : '0;
        n_match = i_cmd.find && (i_index < i_count) && (r_value == i_data);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_value <= n_value;
            r_tap   <= n_tap;
            r_match <= n_match;
        end
    end

    assign o_value = r_value;
    assign o_tap   = r_tap;
    assign o_match = r_match;

endmodule

`default_nettype wire

/* sv/indexed_list_store_core.sv */
// ----------------------------------------------------------------------------
// indexed_list_store_core: bounded ordered list with insert and remove by index
// Top level: command decode, the chain of storage cells, the result
// reduction and the output register.
// ----------------------------------------------------------------------------
// On the accepting edge every cell of the chain acts at once: insert and
// remove shift the entries by one cell, set loads one cell, and get, remove
// and find capture a read tap or a match flag in each cell. In the result
// state S_DONE the registered taps are ORed together and the first match is
// priority-encoded into the output register, after which the next item is
// taken. A stalled output holds the block in S_DONE.
// Entries have no reset; only live positions are ever read.
// ----------------------------------------------------------------------------
`default_nettype none

module indexed_list_store_core
    import ils_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire logic [OP_W-1:0]   i_op,
    input  wire logic [POS_W-1:0]  i_position,
    input  wire logic [DATA_W-1:0] i_data,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output logic                   o_ok,
    output logic [DATA_W-1:0]      o_read_value,
    output logic [FPOS_W-1:0]      o_found_position,
    output logic [LEN_W-1:0]       o_length
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = (CW > POS_W) ? CW : POS_W;

    t_state            r_state;
    t_state            n_state;
    logic [CW-1:0]     r_count;
    logic [CW-1:0]     n_count;
    logic              r_ok_pend;
    logic              n_ok_pend;
    logic              r_find;
    logic              n_find;
    logic              accept;
    logic              load_out;

    t_cell_cmd         cmd;
    t_cell_cmd         cmd_gated;
    logic [PW-1:0]     cmd_pos;
    logic [PW-1:0]     pos_x;
    logic [PW-1:0]     cnt_x;
    logic              not_full;

    logic [DATA_W-1:0] cell_value [CAPACITY];
    logic [DATA_W-1:0] cell_tap   [CAPACITY];
    logic [CAPACITY-1:0] match_vec;
    logic [CAPACITY-1:0] first_vec;
    logic [DATA_W-1:0] tap_or;
    logic [PW-1:0]     first_idx;

    logic              r_out_valid;
    logic              r_out_ok;
    logic [DATA_W-1:0] r_out_rv;
    logic [FPOS_W-1:0] r_out_fp;
    logic [LEN_W-1:0]  r_out_len;

    assign accept = i_valid && !o_stall;

    // Command decode against the current length.
    always_comb begin
        pos_x     = PW'(i_position);
        cnt_x     = PW'(r_count);
        not_full  = (r_count < CW'(CAPACITY));
        cmd       = '0;
        cmd_pos   = pos_x;
        n_ok_pend = 1'b0;
        n_find    = 1'b0;
        n_count   = r_count;
        unique case (t_op'(i_op))
            OP_APPEND: begin
                if (not_full) begin
                    cmd.ins   = 1'b1;
                    cmd_pos   = cnt_x;
                    n_ok_pend = 1'b1;
                    n_count   = r_count + CW'(1);
                end
            end
            OP_INSERT: begin
                if (not_full && (pos_x <= cnt_x)) begin
                    cmd.ins   = 1'b1;
                    n_ok_pend = 1'b1;
                    n_count   = r_count + CW'(1);
                end
            end
            OP_SET: begin
                if (pos_x < cnt_x) begin
                    cmd.wr    = 1'b1;
                    n_ok_pend = 1'b1;
                end
            end
            OP_REMOVE: begin
                if (pos_x < cnt_x) begin
                    cmd.rem   = 1'b1;
                    cmd.rd    = 1'b1;
                    n_ok_pend = 1'b1;
                    n_count   = r_count - CW'(1);
                end
            end
            OP_GET: begin
                if (pos_x < cnt_x) begin
                    cmd.rd    = 1'b1;
                    n_ok_pend = 1'b1;
                end
            end
            OP_FIND: begin
                cmd.find = 1'b1;
                n_find   = 1'b1;
            end
            OP_CLEAR: begin
                n_count   = '0;
                n_ok_pend = 1'b1;
            end
            default: begin
            end
        endcase
        cmd_gated = accept ? cmd : '0;
    end

    // Chain of storage cells; each neighbor link is a fixed wire.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [DATA_W-1:0] left_val;
        logic [DATA_W-1:0] right_val;

        if (g == 0) begin : g_first
            assign left_val = i_data;
        end else begin : g_mid_l
            assign left_val = cell_value[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign right_val = cell_value[g];
        end else begin : g_mid_r
            assign right_val = cell_value[g+1];
        end

        ils_cell #(
            .PW (PW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_en    (accept),
            .i_cmd   (cmd_gated),
            .i_index (PW'(g)),
            .i_pos   (cmd_pos),
            .i_count (cnt_x),
            .i_data  (i_data),
            .i_left  (left_val),
            .i_right (right_val),
            .o_value (cell_value[g]),
            .o_tap   (cell_tap[g]),
            .o_match (match_vec[g])
        );
    end

    // Result reduction: OR of the read taps and encode of the first match.
    always_comb begin
        tap_or    = '0;
        first_idx = '0;
        first_vec = match_vec & (~match_vec + CAPACITY'(1));
        for (int k = 0; k < CAPACITY; k++) begin
            tap_or = tap_or | cell_tap[k];
            if (first_vec[k]) begin
                first_idx = first_idx | PW'(k);
            end
        end
    end

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State outputs.
    always_comb begin
        o_stall  = 1'b1;
        load_out = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_stall = 1'b0;
            end
            S_DONE: begin
                load_out = !r_out_valid || !i_stall;
            end
            default: begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_count <= n_count;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Per-item flags held until the result is formed.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ok_pend <= n_ok_pend;
            r_find    <= n_find;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_ok  <= r_find ? (|match_vec) : r_ok_pend;
            r_out_rv  <= tap_or;
            r_out_fp  <= first_idx[FPOS_W-1:0];
            r_out_len <= LEN_W'(PW'(r_count));
        end
    end

    assign o_valid          = r_out_valid;
    assign o_ok             = r_out_ok;
    assign o_read_value     = r_out_rv;
    assign o_found_position = r_out_fp;
    assign o_length         = r_out_len;

    // The length never exceeds the capacity.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("list length above capacity");

    // The length moves only on an accepted beat.
    a_count_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !accept |=> $stable(r_count))
        else $error("list length changed without an accepted beat");

    // An accepted beat always leads to the result cycle.
    a_accept_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_DONE))
        else $error("accepted beat did not reach the result cycle");

    // A refused operation or failed search returns no data and no position.
    a_refuse_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_ok) |-> ((r_out_rv == '0) && (r_out_fp == '0)))
        else $error("refused result carries data");

endmodule

`default_nettype wire
